// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL; each expects clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/cfrx_pkg.sv =====
`default_nettype none

package cfrx_pkg;

  // Frame geometry
  localparam int MAX_FRAME      = 64;
  localparam int MEM_AW         = $clog2(MAX_FRAME);
  localparam int POS_W          = $clog2(MAX_FRAME + 1);
  localparam int LEN_W          = 16;
  localparam int FRAME_OVERHEAD = 6;
  localparam int MIN_CAPACITY   = 9;
  localparam int MIN_LEN        = 3;
  localparam int PAYLOAD_START  = 6;
  // First position whose arrival adds a settled byte into the checksum
  localparam int SUM_LAG_START  = 7;

  localparam logic [7:0] HDR_FIRST  = 8'hAA;
  localparam logic [7:0] HDR_SECOND = 8'h55;

  // Byte positions with a fixed meaning
  localparam int POS_LEN_LO = 2;
  localparam int POS_LEN_HI = 3;
  localparam int POS_DEVICE = 4;
  localparam int POS_CMD    = 5;

  // Configuration register indexes
  localparam logic REG_CAPACITY = 1'b0;
  localparam logic REG_COMMAND  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_TRAILER = 3'd1,
    ST_BAD_SUM     = 3'd2,
    ST_TOO_SHORT   = 3'd3,
    ST_WRONG_CMD   = 3'd4,
    ST_TIMEOUT     = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_FETCH,
    CS_SEND
  } ctrl_state_e;

  // Controller to datapath
  typedef struct packed {
    logic take;     // accept the word on the input channel
    logic fetch;    // read the current payload byte from the store
    logic advance;  // step to the next payload byte
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic done;     // accepted word produces a result
    logic stream;   // result is a payload stream
    logic last;     // current result word is the final one
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/chain_frame_receiver_top.sv =====
// A word that ends no frame leaves the parser idle and ready for the next; a status or
// timeout result is valid the cycle after the closing word.
// Throughput: one received word per cycle while parsing; payload words leave one at
//   a time, each read from the store and then sent, as the store has a single read port.
// Reset: parser returns to the header hunt, capacity 64, expected command 0;
//   the frame store is not cleared.
`default_nettype none
`include "assert_macros.svh"

module chain_frame_receiver_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  input  logic       is_timeout_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] status_o,
  output logic [7:0] device_index_o,
  output logic       has_data_o,
  output logic [7:0] data_byte_o,
  output logic       last_o
);
  import cfrx_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  cfrx_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cfrx_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .rx_byte_i      (rx_byte_i),
    .is_timeout_i   (is_timeout_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .status_o       (status_o),
    .device_index_o (device_index_o),
    .has_data_o     (has_data_o),
    .data_byte_o    (data_byte_o)
  );

  assign last_o = sts.last;

  // Parsing and sending never overlap
  `ASSERT_IMP(a_no_overlap, in_ready_o, !out_valid_o, "input and output open together")
  // A timeout word reports a timeout next cycle
  `ASSERT_NXT(a_timeout_rep, in_valid_i && in_ready_o && is_timeout_i,
              out_valid_o && status_o == ST_TIMEOUT && last_o, "timeout not reported")
  // A result without data always closes the frame
  `ASSERT_IMP(a_nodata_last, out_valid_o && !has_data_o, last_o, "data-free word not last")
  // The final word returns the block to parsing
  `ASSERT_NXT(a_last_idle, out_valid_o && out_ready_i && last_o, in_ready_o,
              "block not idle after last word")

endmodule

`default_nettype wire

// ===== rtl/cfrx_datapath.sv =====
`default_nettype none

module cfrx_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [7:0]        cfg_data_i,
  input  logic [7:0]        rx_byte_i,
  input  logic              is_timeout_i,
  input  cfrx_pkg::dp_cmd_t cmd_i,
  output cfrx_pkg::dp_sts_t sts_o,
  output logic [2:0]        status_o,
  output logic [7:0]        device_index_o,
  output logic              has_data_o,
  output logic [7:0]        data_byte_o
);
  import cfrx_pkg::*;

  logic [7:0]       mem_q [MAX_FRAME];

  logic [6:0]       cap_cfg_q;
  logic [7:0]       cmd_cfg_q;
  logic [POS_W-1:0] pos_q, pos_d;

  logic [7:0]       len_lo_q, len_hi_q, dev_q, cmd_byte_q;
  logic [7:0]       hist1_q, hist2_q, hist3_q, sum_q;
  logic [7:0]       rdata_q;
  logic [MEM_AW-1:0] rd_idx_q, end_idx_q;
  logic             has_data_q;
  status_e          status_q;

  logic [POS_W-1:0] cap, np;
  logic [LEN_W-1:0] len_cur;
  logic [LEN_W:0]   total, cap_ext, np_ext;
  logic [7:0]       sum_chk;
  logic             wr, fin, timeout;
  status_e          fin_status;

  // Clamp the capacity into the legal frame range
  always_comb begin
    if (cap_cfg_q < 7'(MIN_CAPACITY)) begin
      cap = POS_W'(MIN_CAPACITY);
    end else if (POS_W'(cap_cfg_q) > POS_W'(MAX_FRAME)) begin
      cap = POS_W'(MAX_FRAME);
    end else begin
      cap = POS_W'(cap_cfg_q);
    end
  end

  assign np      = pos_q + POS_W'(1);
  assign len_cur = (pos_q == POS_W'(POS_LEN_HI)) ? {rx_byte_i, len_lo_q}
                                                 : {len_hi_q, len_lo_q};
  assign total   = {1'b0, len_cur} + (LEN_W+1)'(FRAME_OVERHEAD);
  assign cap_ext = (LEN_W+1)'(cap);
  assign np_ext  = (LEN_W+1)'(np);
  assign sum_chk = sum_q + ((pos_q >= POS_W'(SUM_LAG_START)) ? hist3_q : 8'd0);
  assign timeout = cmd_i.take && is_timeout_i;

  // Parse one received word
  always_comb begin
    pos_d      = pos_q;
    wr         = 1'b0;
    fin        = 1'b0;
    fin_status = ST_OK;
    if (cmd_i.take) begin
      if (is_timeout_i) begin
        pos_d      = '0;
        fin        = 1'b1;
        fin_status = ST_TIMEOUT;
      end else if (pos_q == '0 && rx_byte_i != HDR_FIRST) begin
        pos_d = '0;
      end else if (pos_q == POS_W'(1) && rx_byte_i != HDR_SECOND) begin
        pos_d = (rx_byte_i == HDR_FIRST) ? POS_W'(1) : '0;
      end else if (pos_q >= cap) begin
        pos_d = '0;
      end else begin
        wr = 1'b1;
        if (np < POS_W'(POS_DEVICE)) begin
          pos_d = np;
        end else if (total > cap_ext) begin
          pos_d = '0;
        end else if (total != np_ext) begin
          pos_d = np;
        end else begin
          pos_d = '0;
          fin   = 1'b1;
          if (hist1_q != HDR_SECOND || rx_byte_i != HDR_FIRST) begin
            fin_status = ST_BAD_TRAILER;
          end else if (sum_chk != hist2_q) begin
            fin_status = ST_BAD_SUM;
          end else if (len_cur < LEN_W'(MIN_LEN)) begin
            fin_status = ST_TOO_SHORT;
          end else if (cmd_byte_q != cmd_cfg_q) begin
            fin_status = ST_WRONG_CMD;
          end else begin
            fin_status = ST_OK;
          end
        end
      end
    end
  end

  assign sts_o.done   = fin;
  assign sts_o.stream = fin && (fin_status == ST_OK) && (len_cur > LEN_W'(MIN_LEN));
  assign sts_o.last   = !has_data_q || (rd_idx_q == end_idx_q);

  // Control registers and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      cap_cfg_q <= 7'(MAX_FRAME);
      cmd_cfg_q <= '0;
    end else begin
      pos_q <= pos_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_CAPACITY: cap_cfg_q <= cfg_data_i[6:0];
          REG_COMMAND:  cmd_cfg_q <= cfg_data_i;
          default:      cmd_cfg_q <= cmd_cfg_q;
        endcase
      end
    end
  end

  // Frame fields, checksum and history
  always_ff @(posedge clk_i) begin
    if (wr) begin
      hist1_q <= rx_byte_i;
      hist2_q <= hist1_q;
      hist3_q <= hist2_q;
      if (pos_q == '0) begin
        sum_q <= '0;
      end else if (pos_q >= POS_W'(SUM_LAG_START)) begin
        sum_q <= sum_q + hist3_q;
      end
      if (pos_q == POS_W'(POS_LEN_LO)) len_lo_q <= rx_byte_i;
      if (pos_q == POS_W'(POS_LEN_HI)) len_hi_q <= rx_byte_i;
      if (pos_q == POS_W'(POS_DEVICE)) dev_q <= rx_byte_i;
      if (pos_q == POS_W'(POS_CMD))    cmd_byte_q <= rx_byte_i;
    end
    if (timeout) begin
      dev_q <= '0;
    end
    if (fin) begin
      status_q   <= fin_status;
      has_data_q <= sts_o.stream;
      rd_idx_q   <= MEM_AW'(PAYLOAD_START);
      end_idx_q  <= len_cur[MEM_AW-1:0] + MEM_AW'(MIN_LEN - 1);
    end else if (cmd_i.advance) begin
      rd_idx_q <= rd_idx_q + MEM_AW'(1);
    end
  end

  // Frame store: write on collect, registered read on fetch
  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[pos_q[MEM_AW-1:0]] <= rx_byte_i;
    end
    if (cmd_i.fetch) begin
      rdata_q <= mem_q[rd_idx_q];
    end
  end

  assign status_o       = status_q;
  assign device_index_o = dev_q;
  assign has_data_o     = has_data_q;
  assign data_byte_o    = has_data_q ? rdata_q : 8'd0;

endmodule

`default_nettype wire

// ===== rtl/cfrx_ctrl.sv =====
`default_nettype none

module cfrx_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  cfrx_pkg::dp_sts_t sts_i,
  output cfrx_pkg::dp_cmd_t cmd_o
);
  import cfrx_pkg::*;

  ctrl_state_e state_q, state_d;

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Sequence parse, fetch and send
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      CS_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (sts_i.stream) begin
            state_d = CS_FETCH;
          end else if (sts_i.done) begin
            state_d = CS_SEND;
          end
        end
      end
      CS_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = CS_SEND;
      end
      CS_SEND: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (sts_i.last) begin
            state_d = CS_IDLE;
          end else begin
            cmd_o.advance = 1'b1;
            state_d       = CS_FETCH;
          end
        end
      end
      default: state_d = CS_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cfrx_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 2000000;
  localparam int unsigned SETTLE_WAIT  = 4;
  localparam int unsigned FINAL_WAIT   = 16;
  localparam int unsigned PHASE_WORDS  = 48;
  localparam int unsigned ALL_BYTES    = 32'hFFFF_FFFF;
  localparam int unsigned MAX_GAP      = 13;
  localparam int unsigned REPORT_LIMIT = 10;

  // Ways a generated frame can be spoiled
  typedef enum int {
    FRM_GOOD,
    FRM_BAD_TRAILER,
    FRM_BAD_SUM,
    FRM_WRONG_CMD
  } frame_flaw_e;

  typedef struct packed {
    status_e    status;
    logic [7:0] device;
    logic       has_data;
    logic [7:0] data;
    logic       last;
  } reply_t;

  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       cfg_we_i     = 1'b0;
  logic       cfg_idx_i    = REG_CAPACITY;
  logic [7:0] cfg_data_i   = 8'h00;
  logic       in_valid_i   = 1'b0;
  logic       in_ready_o;
  logic [7:0] rx_byte_i    = 8'h00;
  logic       is_timeout_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i  = 1'b0;
  logic [2:0] status_o;
  logic [7:0] device_index_o;
  logic       has_data_o;
  logic [7:0] data_byte_o;
  logic       last_o;

  chain_frame_receiver_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .rx_byte_i     (rx_byte_i),
    .is_timeout_i  (is_timeout_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .device_index_o(device_index_o),
    .has_data_o    (has_data_o),
    .data_byte_o   (data_byte_o),
    .last_o        (last_o)
  );

  // Mirror of the parser state and registers
  logic [7:0]  rx_store [MAX_FRAME];
  int unsigned fill_pos;
  logic [6:0]  capacity_reg;
  logic [7:0]  command_reg;

  reply_t      due_replies [$];
  int unsigned mismatches;
  int unsigned words_sent;
  int unsigned cycles;
  bit          gaps_on = 1'b1;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  function automatic int unsigned draw_gap();
    return gaps_on ? $urandom_range(0, MAX_GAP) : 0;
  endfunction

  // Capacity saturated to the range the frame store supports
  function automatic int unsigned eff_capacity();
    int unsigned cap;
    cap = capacity_reg;
    if (cap < MIN_CAPACITY) cap = MIN_CAPACITY;
    if (cap > MAX_FRAME) cap = MAX_FRAME;
    return cap;
  endfunction

  function automatic void push_reply(input status_e st, input logic [7:0] dev,
                                     input logic has, input logic [7:0] dat,
                                     input logic lst);
    reply_t r;
    r = '{st, dev, has, dat, lst};
    due_replies.push_back(r);
  endfunction

  // Advance the parser mirror by one accepted word and queue what it yields
  function automatic void parse_rx_word(input logic [7:0] b, input logic tmo);
    int unsigned cap;
    int unsigned len;
    int unsigned total;
    logic [7:0]  sum;
    logic [7:0]  dev;
    cap = eff_capacity();
    if (tmo) begin
      fill_pos = 0;
      push_reply(ST_TIMEOUT, 8'h00, 1'b0, 8'h00, 1'b1);
      return;
    end
    if (fill_pos == 0 && b != HDR_FIRST) return;
    if (fill_pos == 1 && b != HDR_SECOND) begin
      fill_pos = (b == HDR_FIRST) ? 1 : 0;
      return;
    end
    // Store full: drop and hunt again
    if (fill_pos >= cap) begin
      fill_pos = 0;
      return;
    end
    rx_store[fill_pos] = b;
    fill_pos++;
    if (fill_pos < 4) return;

    len   = {rx_store[POS_LEN_HI], rx_store[POS_LEN_LO]};
    total = len + FRAME_OVERHEAD;
    if (total > cap) begin
      fill_pos = 0;
      return;
    end
    if (fill_pos != total) return;

    // Frame complete: trailer, checksum, length, command in that order
    fill_pos = 0;
    dev = rx_store[POS_DEVICE];
    sum = 8'h00;
    for (int i = POS_DEVICE; i + 3 < total; i++) sum += rx_store[i];
    if (rx_store[total - 2] != HDR_SECOND || rx_store[total - 1] != HDR_FIRST) begin
      push_reply(ST_BAD_TRAILER, dev, 1'b0, 8'h00, 1'b1);
    end else if (sum != rx_store[total - 3]) begin
      push_reply(ST_BAD_SUM, dev, 1'b0, 8'h00, 1'b1);
    end else if (len < MIN_LEN) begin
      push_reply(ST_TOO_SHORT, dev, 1'b0, 8'h00, 1'b1);
    end else if (rx_store[POS_CMD] != command_reg) begin
      push_reply(ST_WRONG_CMD, dev, 1'b0, 8'h00, 1'b1);
    end else if (len == MIN_LEN) begin
      push_reply(ST_OK, dev, 1'b0, 8'h00, 1'b1);
    end else begin
      for (int i = 0; i < len - MIN_LEN; i++) begin
        push_reply(ST_OK, dev, 1'b1, rx_store[PAYLOAD_START + i],
                   (i + 1 == len - MIN_LEN));
      end
    end
  endfunction

  // Send one word; hold valid and payload until it is taken
  task automatic send_word(input logic [7:0] b, input logic tmo);
    int unsigned gap;
    gap = draw_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    rx_byte_i    <= b;
    is_timeout_i <= tmo;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    parse_rx_word(b, tmo);
    words_sent++;
  endtask

  // Build a frame of the given length and send its first keep bytes
  task automatic send_frame(input logic [15:0] len, input frame_flaw_e flaw,
                            input int unsigned keep);
    logic [7:0]  fb [$];
    logic [7:0]  sum;
    logic [7:0]  bv;
    logic [7:0]  nz;
    int unsigned total;
    int unsigned bad_tr;
    total  = len + FRAME_OVERHEAD;
    nz     = 8'($urandom_range(1, 255));
    bad_tr = $urandom_range(0, 1);
    sum    = 8'h00;
    fb.push_back(HDR_FIRST);
    fb.push_back(HDR_SECOND);
    fb.push_back(len[7:0]);
    fb.push_back(len[15:8]);
    if (total > eff_capacity()) begin
      // Oversize: the block drops it after the length, so send a little tail only
      repeat ($urandom_range(0, 2)) fb.push_back(8'($urandom_range(0, 255)));
    end else begin
      for (int i = POS_DEVICE; i < total; i++) begin
        if (i >= total - 2) begin
          bv = (i == total - 2) ? HDR_SECOND : HDR_FIRST;
          if (flaw == FRM_BAD_TRAILER && i == total - 1 - bad_tr) bv ^= nz;
        end else if (i == total - 3) begin
          bv = (flaw == FRM_BAD_SUM) ? (sum ^ nz) : sum;
        end else begin
          bv = 8'($urandom_range(0, 255));
          if (i == POS_CMD) bv = (flaw == FRM_WRONG_CMD) ? (command_reg ^ nz) : command_reg;
          sum += bv;
        end
        fb.push_back(bv);
      end
    end
    foreach (fb[k]) begin
      if (k < keep) send_word(fb[k], 1'b0);
    end
  endtask

  // Drop valid and hold until every reply is back and the block has settled
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (due_replies.size() != 0) @(posedge clk_i);
    repeat (SETTLE_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] value);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_CAPACITY) capacity_reg = value[6:0];
    else command_reg = value;
  endtask

  // Noise before the header, a repeated first header byte, then a zero-length frame
  task automatic test_header_hunt();
    logic [7:0] seq [10] = '{8'hFF, HDR_FIRST, 8'h13, HDR_FIRST, HDR_FIRST, HDR_SECOND,
                             8'h00, 8'h00, HDR_SECOND, HDR_FIRST};
    foreach (seq[k]) send_word(seq[k], 1'b0);
  endtask

  // Smallest capacity, top command value, frame with no payload
  task automatic test_empty_payload();
    write_reg(REG_CAPACITY, 8'h00);
    write_reg(REG_COMMAND, 8'hFF);
    send_frame(16'(MIN_LEN), FRM_GOOD, ALL_BYTES);
  endtask

  // Length one above what capacity 9 allows, then a frame that fits exactly
  task automatic test_oversize_drop();
    send_frame(16'(MIN_LEN + 1), FRM_GOOD, ALL_BYTES);
    send_frame(16'(MIN_LEN), FRM_BAD_TRAILER, ALL_BYTES);
  endtask

  // Timeout mid-frame returns the parser to the hunt
  task automatic test_timeout();
    send_frame(16'(MIN_LEN), FRM_GOOD, 3);
    send_word(8'hAA, 1'b1);
    send_frame(16'd1, FRM_GOOD, ALL_BYTES);
  endtask

  task automatic test_random_traffic();
    logic [7:0]  caps [6];
    logic [7:0]  cmds [6];
    bit          gaps [6];
    int unsigned start;
    int unsigned pick;
    int unsigned room;
    caps = '{8'd64, 8'd9, 8'd0, 8'hFF, 8'($urandom_range(10, 63)), 8'd30};
    cmds = '{8'h00, 8'hFF, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
             8'($urandom_range(0, 255)), 8'h00};
    gaps = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};
    for (int p = 0; p < 6; p++) begin
      write_reg(REG_CAPACITY, caps[p]);
      write_reg(REG_COMMAND, cmds[p]);
      gaps_on = gaps[p];
      start = words_sent;
      while (words_sent - start < PHASE_WORDS) begin
        pick = $urandom_range(0, 99);
        room = eff_capacity() - FRAME_OVERHEAD;
        if (pick < 58) begin
          send_frame(16'($urandom_range(0, (room < 14) ? room : 14)), FRM_GOOD, ALL_BYTES);
        end else if (pick < 70) begin
          send_frame(16'($urandom_range(0, room)), frame_flaw_e'($urandom_range(1, 3)),
                     ALL_BYTES);
        end else if (pick < 78) begin
          if ($urandom_range(0, 1) == 0) send_frame(16'($urandom_range(room + 1, room + 8)),
                                                    FRM_GOOD, ALL_BYTES);
          else send_frame(16'($urandom_range(room + 1, 16'hFFFF)), FRM_GOOD, ALL_BYTES);
        end else if (pick < 86) begin
          repeat ($urandom_range(1, 3)) begin
            send_word(($urandom_range(0, 2) == 0) ? HDR_FIRST : 8'($urandom_range(0, 255)),
                      1'b0);
          end
        end else if (pick < 92) begin
          send_frame(16'($urandom_range(MIN_LEN, room)), FRM_GOOD, $urandom_range(1, 5));
          send_word(8'($urandom_range(0, 255)), 1'b1);
        end else if (pick < 95) begin
          send_word(8'($urandom_range(0, 255)), 1'b1);
        end else begin
          send_frame(16'(($urandom_range(0, 2) == 0) ? room : $urandom_range(MIN_LEN, room)),
                     FRM_GOOD, ALL_BYTES);
        end
      end
    end
  endtask

  // Drain replies with random backpressure
  initial begin : reply_sink
    int unsigned gap;
    @(posedge clk_i);
    forever begin
      gap = draw_gap();
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // Compare each reply word against the oldest one due
  always @(posedge clk_i) begin
    reply_t got;
    reply_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{status_e'(status_o), device_index_o, has_data_o, data_byte_o, last_o};
      if (due_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("reply with none due: st %0d dev %02h has %0b data %02h last %0b",
                   got.status, got.device, got.has_data, got.data, got.last);
        end
      end else begin
        want = due_replies.pop_front();
        if (got.status !== want.status || got.device !== want.device ||
            got.has_data !== want.has_data || got.data !== want.data ||
            got.last !== want.last) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("reply mismatch: want st %0d dev %02h has %0b data %02h last %0b",
                     want.status, want.device, want.has_data, want.data, want.last);
            $display("                got  st %0d dev %02h has %0b data %02h last %0b",
                     got.status, got.device, got.has_data, got.data, got.last);
          end
        end
      end
    end
  end

  initial begin
    fill_pos     = 0;
    capacity_reg = 7'd64;
    command_reg  = 8'h00;
    foreach (rx_store[k]) rx_store[k] = 8'h00;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_header_hunt();
    test_empty_payload();
    test_oversize_drop();
    test_timeout();
    test_random_traffic();

    wait_idle();
    repeat (FINAL_WAIT) @(posedge clk_i);
    if (mismatches == 0 && due_replies.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
